FILE: design/c2psp_pkg.sv
// Package for the chunky-to-planar sprite packer.
// Holds parameter defaults, register map codes and register reset values.
// No dependencies.
package c2psp_pkg;

  localparam int unsigned MAX_ROW_PIXELS_DEF = 16;
  localparam int unsigned MAX_PLANES_DEF     = 2;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_WIDTH_BYTES = 2'd0;
  localparam logic [1:0] REG_SPRITE_ROWS = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT = 2'd2;

  localparam logic [1:0] WIDTH_BYTES_RST = 2'd2;
  localparam logic [9:0] SPRITE_ROWS_RST = 10'd16;
  localparam logic [1:0] PLANE_COUNT_RST = 2'd2;

  localparam int unsigned TRAILER_LEN = 4;

endpackage

FILE: design/chunky_to_planar_sprite_packer_core.sv
// Chunky-to-planar sprite packer, top level.
// Row buffer, two-entry row-job queue, byte emitter and APB register file.
// Depends on c2psp_pkg.

// Takes one chunky pixel per clock in row-major order and returns planar sprite bytes, one
// per clock, on a separate output beat. A pixel beat is accepted every cycle but for the
// stall below; the pixel that closes a row snapshots the packed planes into a two-entry job
// queue, and the emitter drains each job as 4 header bytes (first row only), plane_count *
// width_bytes data bytes (each clamped to 1..max) and 4 trailer bytes (last row only, final
// one flagged by last_byte), so a row yields 1 to 12 bytes. The pixel side stalls only on a
// row-closing pixel while both queue entries are full, which the emitter's single byte per
// cycle and the output stall decide. The user must write registers via APB while the block
// is idle; the block does not enforce it. Each register reads back its written low bits.
module chunky_to_planar_sprite_packer_core #(
  parameter int unsigned MAX_ROW_PIXELS = c2psp_pkg::MAX_ROW_PIXELS_DEF,
  parameter int unsigned MAX_PLANES     = c2psp_pkg::MAX_PLANES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [c2psp_pkg::ADDR_W-1:0]   paddr,
  input  logic [c2psp_pkg::DATA_W-1:0]   pwdata,
  output logic [c2psp_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic [7:0]                     pixel,
  output logic                           byte_valid,
  input  logic                           byte_stall,
  output logic [7:0]                     out_byte,
  output logic                           last_byte
);
  import c2psp_pkg::*;

  localparam int unsigned MAX_WB = MAX_ROW_PIXELS / 8;
  localparam int unsigned CW     = $clog2(MAX_ROW_PIXELS);
  localparam int unsigned BW     = (MAX_WB > 1) ? $clog2(MAX_WB) : 1;
  localparam int unsigned PW     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_TRL  = 2'd3;

  localparam logic [1:0] LAST_CNT = 2'(TRAILER_LEN - 1);

  typedef struct packed {
    logic                                  hdr;
    logic                                  trl;
    logic [BW-1:0]                         wb_m1;
    logic [PW-1:0]                         pl_m1;
    logic [MAX_PLANES-1:0][MAX_WB-1:0][7:0] data;
  } job_t;

  // registers
  logic [1:0] width_bytes;
  logic [9:0] sprite_rows;
  logic [1:0] plane_count;

  logic [MAX_PLANES-1:0] row_store [MAX_ROW_PIXELS];
  logic [CW-1:0]         column_count;
  logic [9:0]            row_count;

  job_t       jobs [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] job_count;

  logic [1:0]    st;
  logic [1:0]    cnt;
  logic [PW-1:0] pl;
  logic [BW-1:0] by;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_bytes <= WIDTH_BYTES_RST;
      sprite_rows <= SPRITE_ROWS_RST;
      plane_count <= PLANE_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH_BYTES: width_bytes <= pwdata[1:0];
        REG_SPRITE_ROWS: sprite_rows <= pwdata[9:0];
        REG_PLANE_COUNT: plane_count <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH_BYTES: prdata = DATA_W'(width_bytes);
      REG_SPRITE_ROWS: prdata = DATA_W'(sprite_rows);
      REG_PLANE_COUNT: prdata = DATA_W'(plane_count);
      default:         prdata = '0;
    endcase
  end

  // effective settings
  logic [1:0]    wb_sel, pl_sel;
  logic [10:0]   rows_eff;
  logic [CW:0]   row_pixels;
  logic          row_end, first_row, last_row;
  logic          pix_accept, push, pop;
  job_t          new_job;

  always_comb begin
    if (width_bytes == 2'd0) wb_sel = 2'd1;
    else if (width_bytes > 2'(MAX_WB)) wb_sel = 2'(MAX_WB);
    else wb_sel = width_bytes;
    if (plane_count == 2'd0) pl_sel = 2'd1;
    else if (plane_count > 2'(MAX_PLANES)) pl_sel = 2'(MAX_PLANES);
    else pl_sel = plane_count;
    rows_eff   = (sprite_rows == 10'd0) ? 11'd1 : {1'b0, sprite_rows};
    row_pixels = (CW+1)'({wb_sel, 3'b000});
    row_end    = ({1'b0, column_count} + (CW+1)'(1)) >= row_pixels;
    first_row  = (row_count == 10'd0);
    last_row   = ({1'b0, row_count} + 11'd1) >= rows_eff;
  end

  assign pixel_stall = (job_count == 2'd2) && row_end;
  assign pix_accept  = pixel_valid && !pixel_stall;
  assign push        = pix_accept && row_end;

  always_comb begin
    logic [MAX_PLANES-1:0] v [MAX_ROW_PIXELS];
    for (int i = 0; i < MAX_ROW_PIXELS; i++) begin
      v[i] = (CW'(i) == column_count) ? pixel[MAX_PLANES-1:0] : row_store[i];
    end
    new_job.hdr   = first_row;
    new_job.trl   = last_row;
    new_job.wb_m1 = BW'(wb_sel - 2'd1);
    new_job.pl_m1 = PW'(pl_sel - 2'd1);
    for (int p = 0; p < MAX_PLANES; p++) begin
      for (int b = 0; b < MAX_WB; b++) begin
        for (int k = 0; k < 8; k++) begin
          new_job.data[p][b][7-k] = v[b*8+k][p];
        end
      end
    end
  end

  // row buffer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ROW_PIXELS; i++) row_store[i] <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (pix_accept) begin
      row_store[column_count] <= pixel[MAX_PLANES-1:0];
      if (row_end) begin
        column_count <= '0;
        row_count    <= last_row ? 10'd0 : row_count + 10'd1;
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // job queue
  job_t head;
  assign head = jobs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) jobs[wr_ptr] <= new_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      job_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      job_count <= job_count + 2'(push) - 2'(pop);
    end
  end

  // byte emitter
  logic          emit_go;
  logic [1:0]    phase;
  logic [1:0]    st_next, cnt_next;
  logic [PW-1:0] pl_next;
  logic [BW-1:0] by_next;
  logic [7:0]    byte_next;
  logic          last_next;
  logic          job_done;

  assign emit_go = (job_count != 2'd0) && (!byte_valid || !byte_stall);
  assign pop     = emit_go && job_done;

  always_comb begin
    phase     = (st == S_IDLE) ? (head.hdr ? S_HDR : S_DATA) : st;
    st_next   = phase;
    cnt_next  = cnt;
    pl_next   = pl;
    by_next   = by;
    byte_next = 8'd0;
    last_next = 1'b0;
    job_done  = 1'b0;
    case (phase)
      S_HDR: begin
        if (cnt == LAST_CNT) begin
          st_next  = S_DATA;
          cnt_next = 2'd0;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      S_DATA: begin
        byte_next = head.data[pl][by];
        if (by == head.wb_m1) begin
          by_next = '0;
          if (pl == head.pl_m1) begin
            pl_next = '0;
            if (head.trl) begin
              st_next = S_TRL;
            end else begin
              st_next  = S_IDLE;
              job_done = 1'b1;
            end
          end else begin
            pl_next = pl + PW'(1);
          end
        end else begin
          by_next = by + BW'(1);
        end
      end
      S_TRL: begin
        if (cnt == LAST_CNT) begin
          last_next = 1'b1;
          st_next   = S_IDLE;
          cnt_next  = 2'd0;
          job_done  = 1'b1;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_IDLE;
      cnt <= 2'd0;
      pl  <= '0;
      by  <= '0;
    end else if (emit_go) begin
      st  <= st_next;
      cnt <= cnt_next;
      pl  <= pl_next;
      by  <= by_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (emit_go) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_byte  <= byte_next;
      last_byte <= last_next;
    end
  end

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    job_count != 2'd3)
    else $error("job queue over capacity");

  a_trl_flag: assert property (@(posedge clk) disable iff (rst)
    (st == S_TRL) |-> (job_count != 2'd0) && head.trl)
    else $error("trailer emitted for a job without the trailer flag");

  a_hdr_flag: assert property (@(posedge clk) disable iff (rst)
    (st == S_HDR) |-> (job_count != 2'd0) && head.hdr)
    else $error("header emitted for a job without the header flag");

  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && last_byte) |-> (out_byte == 8'd0))
    else $error("last byte not a trailer byte");

endmodule

FILE: bench/tb_chunky_to_planar_sprite_packer_core.sv
// Testbench for chunky_to_planar_sprite_packer_core: random and directed pixel streams,
// APB register settings and a scoreboard that predicts each planar byte beat.
// Depends on c2psp_pkg and the core RTL.
module tb_chunky_to_planar_sprite_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import c2psp_pkg::*;

  localparam int HEADER_LEN = 4;
  localparam int IDLE_PCT = 28;
  localparam int RANDOM_ITEMS = 380;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } planar_beat_t;

  class planar_scoreboard;
    logic [MAX_PLANES_DEF-1:0] row_px [MAX_ROW_PIXELS_DEF];
    logic [3:0] col;
    logic [9:0] row;
    logic [1:0] width_reg;
    logic [9:0] rows_reg;
    logic [1:0] planes_reg;
    planar_beat_t planar_bytes_q[$];
    int errors;

    function new();
      foreach (row_px[i]) row_px[i] = '0;
      col = '0;
      row = '0;
      width_reg = WIDTH_BYTES_RST;
      rows_reg = SPRITE_ROWS_RST;
      planes_reg = PLANE_COUNT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH_BYTES: width_reg = value[1:0];
        REG_SPRITE_ROWS: rows_reg = value[9:0];
        REG_PLANE_COUNT: planes_reg = value[1:0];
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] d, logic l);
      planar_bytes_q.push_back('{data: d, last: l});
    endfunction

    function void take_pixel(logic [7:0] px);
      int unsigned wb, np, nr, row_len;
      logic [7:0] packed_bits;
      wb = (width_reg == 0) ? 1 : width_reg;
      if (wb > MAX_ROW_PIXELS_DEF / 8) wb = MAX_ROW_PIXELS_DEF / 8;
      np = (planes_reg == 0) ? 1 : planes_reg;
      if (np > MAX_PLANES_DEF) np = MAX_PLANES_DEF;
      nr = (rows_reg == 0) ? 1 : rows_reg;
      row_len = wb * 8;
      row_px[col] = px[MAX_PLANES_DEF-1:0];
      if (int'(col) + 1 < row_len) begin
        col = col + 1'b1;
        return;
      end
      col = '0;
      if (row == 0) begin
        for (int k = 0; k < HEADER_LEN; k++) push(8'h00, 1'b0);
      end
      for (int p = 0; p < np; p++) begin
        for (int b = 0; b < wb; b++) begin
          packed_bits = '0;
          for (int k = 0; k < 8; k++) packed_bits = {packed_bits[6:0], row_px[b*8+k][p]};
          push(packed_bits, 1'b0);
        end
      end
      if (int'(row) + 1 >= nr) begin
        for (int k = 0; k < TRAILER_LEN; k++) push(8'h00, k == TRAILER_LEN - 1);
        row = '0;
      end else begin
        row = row + 1'b1;
      end
    endfunction

    function void check_beat(logic [7:0] d, logic l);
      planar_beat_t e;
      if (planar_bytes_q.size() == 0) begin
        $display("%0t: unexpected beat, actual byte %h last %b", $time, d, l);
        errors++;
        return;
      end
      e = planar_bytes_q.pop_front();
      if (d !== e.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.data, d);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return planar_bytes_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic [7:0]        pixel = '0;
  logic              byte_valid;
  logic              byte_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              last_byte;

  planar_scoreboard sb;
  bit idle_on = 1'b1;
  int cycle_count = 0;
  int items_sent;

  chunky_to_planar_sprite_packer_core u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .out_byte(out_byte),
    .last_byte(last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    byte_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) sb.take_pixel(pixel);
      if (byte_valid && !byte_stall) sb.check_beat(out_byte, last_byte);
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] value);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    static logic [7:0] edge_px [8] = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h03, 8'hFE};
    int n, phase, sel;
    bit wrote;
    sb = new();
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-row sprite, one byte wide, two planes
    apb_write(REG_WIDTH_BYTES, 32'd1);
    apb_write(REG_SPRITE_ROWS, 32'd1);
    apb_write(REG_PLANE_COUNT, 32'd2);
    apb_release();
    foreach (edge_px[i]) send_pixel(edge_px[i]);
    wait_drained();

    // out-of-range settings, then shrink the row and the sprite mid-way
    apb_write(REG_WIDTH_BYTES, 32'd3);
    apb_write(REG_PLANE_COUNT, 32'd0);
    apb_write(REG_SPRITE_ROWS, 32'd1023);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    apb_release();
    repeat (12) send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
    apb_write(REG_WIDTH_BYTES, 32'd0);
    apb_release();
    send_pixel(8'($urandom_range(0, 255)));
    wait_drained();
    apb_write(REG_SPRITE_ROWS, 32'd0);
    apb_write(REG_PLANE_COUNT, 32'd3);
    apb_release();
    repeat (8) send_pixel(8'($urandom_range(0, 255)));

    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      wrote = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1)) begin
          apb_write(REG_WIDTH_BYTES, 32'($urandom_range(0, 3)));
          wrote = 1'b1;
        end
        if ($urandom_range(0, 1)) begin
          apb_write(REG_PLANE_COUNT, 32'($urandom_range(0, 3)));
          wrote = 1'b1;
        end
        if ($urandom_range(0, 1)) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) apb_write(REG_SPRITE_ROWS, 32'd0);
          else if (sel == 1) apb_write(REG_SPRITE_ROWS, 32'd1023);
          else if (sel == 2) apb_write(REG_SPRITE_ROWS, 32'($urandom_range(0, 1023)));
          else apb_write(REG_SPRITE_ROWS, 32'($urandom_range(1, 3)));
          wrote = 1'b1;
        end
        if (wrote) apb_release();
      end
      idle_on = !(phase >= 4 && phase < 7);
      n = $urandom_range(1, 48);
      repeat (n) send_pixel(8'($urandom_range(0, 255)));
      phase++;
    end

    idle_on = 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
